// ----- hw/rtl/tksd_pkg.sv -----
// Package: types, action codes and byte constants for the key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

  localparam int SEQ_DEPTH_DEF = 8;
  localparam logic [15:0] ESC_TIMEOUT_RST = 16'd50;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_SEQ    = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ACT_NONE      = 5'd0,
    ACT_INSERT    = 5'd1,
    ACT_BACKSPACE = 5'd2,
    ACT_ENTER     = 5'd3,
    ACT_COMPLETE  = 5'd4,
    ACT_HOME      = 5'd5,
    ACT_LEFT      = 5'd6,
    ACT_RIGHT     = 5'd7,
    ACT_END       = 5'd8,
    ACT_INTERRUPT = 5'd9,
    ACT_KILLEND   = 5'd10,
    ACT_CLEAR     = 5'd11,
    ACT_KILLHOME  = 5'd12,
    ACT_DELWORD   = 5'd13,
    ACT_HISTUP    = 5'd14,
    ACT_HISTDOWN  = 5'd15,
    ACT_DELETE    = 5'd16,
    ACT_SEARCH    = 5'd17
  } action_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CTRLA = 8'h01;
  localparam logic [7:0] CH_CTRLB = 8'h02;
  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_CTRLE = 8'h05;
  localparam logic [7:0] CH_CTRLF = 8'h06;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CTRLK = 8'h0B;
  localparam logic [7:0] CH_CTRLL = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CTRLR = 8'h12;
  localparam logic [7:0] CH_CTRLU = 8'h15;
  localparam logic [7:0] CH_CTRLW = 8'h17;
  localparam logic [7:0] CH_CTRLZ = 8'h1A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Ctrl letter actions, other control bytes give none.
  function automatic action_t ctrl_action(input logic [7:0] b);
    action_t a;
    unique case (b)
      CH_CTRLA: a = ACT_HOME;
      CH_CTRLB: a = ACT_LEFT;
      CH_CTRLC: a = ACT_INTERRUPT;
      CH_CTRLE: a = ACT_END;
      CH_CTRLF: a = ACT_RIGHT;
      CH_CTRLK: a = ACT_KILLEND;
      CH_CTRLL: a = ACT_CLEAR;
      CH_CTRLR: a = ACT_SEARCH;
      CH_CTRLU: a = ACT_KILLHOME;
      CH_CTRLW: a = ACT_DELWORD;
      default:  a = ACT_NONE;
    endcase
    return a;
  endfunction

  // Final byte of "ESC [ x".
  function automatic action_t csi_action(input logic [7:0] b);
    action_t a;
    unique case (b)
      CH_UA:   a = ACT_HISTUP;
      CH_UB:   a = ACT_HISTDOWN;
      CH_UC:   a = ACT_RIGHT;
      CH_UD:   a = ACT_LEFT;
      CH_UH:   a = ACT_HOME;
      CH_UF:   a = ACT_END;
      default: a = ACT_NONE;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/terminal_key_sequence_decoder.sv -----
// Top level: console byte stream to line-editing key action decoder.
`timescale 1ns / 1ps

// Takes one transaction per cycle on the input stream: tuser = 0 carries a
// received byte, tuser = 1 a millisecond tick. Each byte yields one action
// transaction in the next cycle; ticks yield none and only advance the escape
// timer. The whole decode sits between the input handshake and a single
// output register; input stalls only while the output register is full and
// not taken. The user must write the timeout register through the cfg_
// channel only while idle; the block itself does not enforce it.
module terminal_key_sequence_decoder #(
  parameter int SEQ_DEPTH = tksd_pkg::SEQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // esc_timeout_ticks

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] mode

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [4:0] action, [12:5] key_char, [15:13] zero
);

  import tksd_pkg::*;

  localparam int LEN_W = $clog2(SEQ_DEPTH + 1);
  localparam int KEEP  = 3;  // decode looks at the first three bytes only

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        timeout_r;
  logic [7:0]         seq_r [KEEP];
  logic               seq_we;
  logic [1:0]         seq_idx;

  logic               out_valid_r;
  action_t            act_r, act_nxt;
  logic [7:0]         char_r, char_nxt;

  logic               in_fire;
  logic               byte_fire;
  logic [7:0]         b;
  phase_t             phase_eff;
  logic               not_full;
  logic               is_final;
  logic [7:0]         b1, b2;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign byte_fire  = in_fire && !in_tuser;
  assign b          = in_tdata;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, char_r, act_r};

  assign not_full = len_r < LEN_W'(SEQ_DEPTH);
  assign is_final = (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) ||
                    (b == CH_TILDE);
  assign b1 = (len_r == LEN_W'(1)) ? b : seq_r[1];
  assign b2 = (len_r == LEN_W'(2)) ? b : seq_r[2];

  always_comb begin
    phase_eff = phase_r;
    if ((phase_r == PH_ESC || phase_r == PH_SEQ) && elapsed_r > timeout_r) begin
      phase_eff = PH_NORMAL;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    act_nxt     = ACT_NONE;
    char_nxt    = CH_NUL;
    seq_we      = 1'b0;
    seq_idx     = len_r[1:0];
    if (in_fire && in_tuser) begin
      if (elapsed_r != 16'hFFFF) begin
        elapsed_nxt = elapsed_r + 16'd1;
      end
    end else if (byte_fire) begin
      unique case (phase_eff)
        PH_ESC: begin
          if (b == CH_LBRK || b == CH_UO) begin
            seq_we      = not_full && (len_r < LEN_W'(KEEP));
            len_nxt     = not_full ? len_r + LEN_W'(1) : len_r;
            phase_nxt   = PH_SEQ;
            elapsed_nxt = 16'd0;
          end else begin
            phase_nxt = PH_NORMAL;
          end
        end
        PH_SEQ: begin
          seq_we  = not_full && (len_r < LEN_W'(KEEP));
          len_nxt = not_full ? len_r + LEN_W'(1) : len_r;
          if (is_final) begin
            phase_nxt = PH_NORMAL;
            if (not_full && len_r == LEN_W'(1)) begin
              if (seq_r[0] == CH_LBRK) begin
                act_nxt = csi_action(b1);
              end else if (seq_r[0] == CH_UO && b1 == CH_UH) begin
                act_nxt = ACT_HOME;
              end else if (seq_r[0] == CH_UO && b1 == CH_UF) begin
                act_nxt = ACT_END;
              end
            end else if (not_full && len_r == LEN_W'(2)) begin
              if (seq_r[0] == CH_LBRK && b1 == CH_THREE && b2 == CH_TILDE) begin
                act_nxt = ACT_DELETE;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
          if (b == CH_ESC) begin
            phase_nxt   = PH_ESC;
            len_nxt     = '0;
            elapsed_nxt = 16'd0;
          end else if (b == CH_TAB) begin
            act_nxt = ACT_COMPLETE;
          end else if (b == CH_CR || b == CH_LF) begin
            act_nxt = ACT_ENTER;
          end else if (b == CH_DEL || b == CH_BS) begin
            act_nxt = ACT_BACKSPACE;
          end else if (b >= CH_CTRLA && b <= CH_CTRLZ) begin
            act_nxt = ctrl_action(b);
          end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            act_nxt  = ACT_INSERT;
            char_nxt = b;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NORMAL;
      len_r       <= '0;
      elapsed_r   <= 16'd0;
      timeout_r   <= ESC_TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (byte_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      act_r  <= act_nxt;
      char_r <= char_nxt;
    end
    if (seq_we) begin
      seq_r[seq_idx] <= b;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the console key sequence decoder: directed and random byte/tick streams
`timescale 1ns / 1ps

module tb_top;
  import tksd_pkg::*;

  localparam int SEQ_LEN = SEQ_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned BYTES_PER_PHASE = 65;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LX   = 8'h78;

  typedef enum logic [1:0] {K_BYTE, K_TICK, K_CFG, K_PAUSE} stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    logic [15:0] value;
    int unsigned gap;
  } stim_t;

  typedef struct {
    action_t    act;
    logic [7:0] ch;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] byte_value
  logic        in_tuser = 1'b0; // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [4:0] action, [12:5] key_char

  terminal_key_sequence_decoder #(.SEQ_DEPTH(SEQ_LEN)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // decoder shadow state
  phase_t      ph = PH_NORMAL;
  logic [7:0]  seq_buf [SEQ_LEN];
  int unsigned seq_cnt = 0;
  logic [15:0] tick_cnt = '0;
  logic [15:0] esc_limit = ESC_TIMEOUT_RST;

  stim_t       stim_q [$];
  key_result_t key_q [$];
  int unsigned n_err = 0;
  int unsigned n_bytes = 0;
  int unsigned calm_left = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_err++;
  endtask

  function automatic action_t ctrl_key(input logic [7:0] b);
    case (b)
      CH_CTRLA: return ACT_HOME;
      CH_CTRLB: return ACT_LEFT;
      CH_CTRLC: return ACT_INTERRUPT;
      CH_CTRLE: return ACT_END;
      CH_CTRLF: return ACT_RIGHT;
      CH_CTRLK: return ACT_KILLEND;
      CH_CTRLL: return ACT_CLEAR;
      CH_CTRLR: return ACT_SEARCH;
      CH_CTRLU: return ACT_KILLHOME;
      CH_CTRLW: return ACT_DELWORD;
      default:  return ACT_NONE;
    endcase
  endfunction

  function automatic action_t seq_key();
    if (seq_cnt < 2) return ACT_NONE;
    if (seq_buf[0] == CH_LBRK) begin
      if (seq_cnt == 2) begin
        case (seq_buf[1])
          CH_UA:   return ACT_HISTUP;
          CH_UB:   return ACT_HISTDOWN;
          CH_UC:   return ACT_RIGHT;
          CH_UD:   return ACT_LEFT;
          CH_UH:   return ACT_HOME;
          CH_UF:   return ACT_END;
          default: return ACT_NONE;
        endcase
      end
      if (seq_cnt == 3 && seq_buf[1] == CH_THREE && seq_buf[2] == CH_TILDE) return ACT_DELETE;
      return ACT_NONE;
    end
    if (seq_buf[0] == CH_UO && seq_cnt == 2) begin
      if (seq_buf[1] == CH_UH) return ACT_HOME;
      if (seq_buf[1] == CH_UF) return ACT_END;
    end
    return ACT_NONE;
  endfunction

  function automatic key_result_t plain_key(input logic [7:0] b);
    key_result_t r;
    r.act = ACT_NONE;
    r.ch = 8'h00;
    if (b == CH_ESC) begin
      ph = PH_ESC;
      seq_cnt = 0;
      tick_cnt = '0;
    end else if (b == CH_TAB) r.act = ACT_COMPLETE;
    else if (b == CH_CR || b == CH_LF) r.act = ACT_ENTER;
    else if (b == CH_DEL || b == CH_BS) r.act = ACT_BACKSPACE;
    else if (b >= CH_CTRLA && b <= CH_CTRLZ) r.act = ctrl_key(b);
    else if (b >= CH_SPACE && b <= CH_TILDE) begin
      r.act = ACT_INSERT;
      r.ch = b;
    end
    return r;
  endfunction

  task automatic hold_byte(input logic [7:0] b);
    if (seq_cnt < SEQ_LEN) begin
      seq_buf[seq_cnt] = b;
      seq_cnt++;
    end
  endtask

  task automatic decode_item(input logic is_tick, input logic [7:0] b);
    key_result_t r;
    r.act = ACT_NONE;
    r.ch = 8'h00;
    if (is_tick) begin
      if (tick_cnt != 16'hFFFF) tick_cnt++;
    end else begin
      if ((ph == PH_ESC || ph == PH_SEQ) && tick_cnt > esc_limit) ph = PH_NORMAL;
      case (ph)
        PH_ESC: begin
          if (b == CH_LBRK || b == CH_UO) begin
            hold_byte(b);
            ph = PH_SEQ;
            tick_cnt = '0;
          end else begin
            ph = PH_NORMAL;
          end
        end
        PH_SEQ: begin
          hold_byte(b);
          if ((b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_TILDE) begin
            r.act = seq_key();
            ph = PH_NORMAL;
          end
        end
        default: begin
          ph = PH_NORMAL;
          r = plain_key(b);
        end
      endcase
      key_q.push_back(r);
    end
  endtask

  // sender: random gaps between items, with occasional back-to-back stretches
  function automatic int unsigned draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  task automatic push_item(input stim_kind_t kind, input logic [15:0] value,
                           input int unsigned gap);
    stim_t it;
    it.kind = kind;
    it.value = value;
    it.gap = gap;
    stim_q.push_back(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(K_BYTE, {8'h00, b}, draw_gap());
    n_bytes++;
  endtask

  task automatic push_ticks(input int unsigned n, input bit fast);
    for (int unsigned i = 0; i < n; i++) push_item(K_TICK, '0, fast ? 0 : draw_gap());
  endtask

  task automatic push_pause();
    push_item(K_PAUSE, '0, draw_gap());
  endtask

  task automatic push_cfg(input logic [15:0] v);
    push_pause();
    push_item(K_CFG, v, draw_gap());
  endtask

  function automatic int unsigned tick_burst(input int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (limit <= 64 && r < 90) begin
      if (limit > 0 && r < 68) return limit - 1;
      return limit + $urandom_range(0, 1);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] final_byte();
    case ($urandom_range(0, 2))
      0:       return 8'(CH_UA + $urandom_range(0, 25));
      1:       return 8'(CH_LA + $urandom_range(0, 25));
      default: return CH_TILDE;
    endcase
  endfunction

  task automatic push_escape(input int unsigned limit);
    logic [7:0] arrows [6];
    int unsigned pick, n;
    arrows = '{CH_UA, CH_UB, CH_UC, CH_UD, CH_UH, CH_UF};
    push_byte(CH_ESC);
    push_ticks(tick_burst(limit), 1'b0);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(pick < 7 ? CH_LBRK : CH_UO);
      push_ticks(tick_burst(limit), 1'b0);
      case ($urandom_range(0, 5))
        0, 1: push_byte(arrows[$urandom_range(0, 5)]);
        2: begin
          push_byte(CH_THREE);
          push_byte(CH_TILDE);
        end
        3: begin
          n = $urandom_range(0, 4);
          for (int unsigned i = 0; i < n; i++) push_byte(8'(CH_ZERO + $urandom_range(0, 11)));
          push_byte(final_byte());
        end
        4: begin
          n = $urandom_range(0, 3);
          for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          n = $urandom_range(SEQ_LEN - 1, SEQ_LEN + 3);
          for (int unsigned i = 0; i < n; i++) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
          push_byte(final_byte());
        end
      endcase
    end
  endtask

  // driver
  stim_t       cur;
  int unsigned gap_left = 0;
  int unsigned settle_left = 0;
  bit          pause_wait = 1'b0;
  bit          drive_in, drive_cfg;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_item(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) esc_limit = cfg_data;
      if (!((in_tvalid && !in_tready) || (cfg_valid && !cfg_ready))) begin
        drive_in = 1'b0;
        drive_cfg = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pause_wait) begin
          if (key_q.size() == 0) begin
            if (settle_left > 0) settle_left--;
            else pause_wait = 1'b0;
          end
        end else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          gap_left = cur.gap;
          case (cur.kind)
            K_BYTE: begin
              drive_in = 1'b1;
              in_tuser <= 1'b0;
              in_tdata <= cur.value[7:0];
            end
            K_TICK: begin
              drive_in = 1'b1;
              in_tuser <= 1'b1;
              in_tdata <= 8'($urandom_range(0, 255));
            end
            K_CFG: begin
              drive_cfg = 1'b1;
              cfg_data <= cur.value;
            end
            default: begin
              pause_wait = 1'b1;
              settle_left = 4;
            end
          endcase
        end
        in_tvalid <= drive_in;
        cfg_valid <= drive_cfg;
      end
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned rdy_calm = 0;
  key_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (key_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = key_q.pop_front();
          if (out_tdata[4:0] !== want.act)
            report_mismatch($sformatf("action %0d, expected %s", out_tdata[4:0],
                                      want.act.name()));
          if (out_tdata[12:5] !== want.ch)
            report_mismatch($sformatf("key_char %h, expected %h", out_tdata[12:5],
                                      want.ch));
        end
        if (rdy_calm > 0) begin
          rdy_calm--;
          stall_left = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) rdy_calm = $urandom_range(10, 40);
          stall_left = $urandom_range(0, 5);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_tready <= (stall_left == 0);
    end
  end

  // watchdog
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (cfg_valid && cfg_ready) ||
        (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] limits [9];
    int unsigned base, sel;

    // directed: plain bytes and control actions
    push_byte(CH_UA); push_byte(CH_SPACE); push_byte(CH_TILDE); push_byte(CH_NUL);
    push_byte(8'hFF); push_byte(8'h80); push_byte(CH_DEL); push_byte(CH_TAB);
    push_byte(CH_CR); push_byte(CH_CTRLC); push_byte(CH_CTRLK); push_byte(CH_CTRLL);
    push_byte(CH_CTRLR); push_byte(CH_CTRLU); push_byte(CH_CTRLW); push_byte(CH_CTRLZ);
    // escape sequences
    push_byte(CH_ESC); push_byte(CH_LBRK); push_byte(CH_UA);
    push_byte(CH_ESC); push_byte(CH_LBRK); push_byte(CH_UB);
    push_byte(CH_ESC); push_byte(CH_UO); push_byte(CH_UH);
    push_byte(CH_ESC); push_byte(CH_LBRK); push_byte(CH_THREE); push_byte(CH_TILDE);
    // lone escape
    push_byte(CH_ESC); push_byte(CH_LX);
    // overfull buffer, final byte still closes it
    push_byte(CH_ESC); push_byte(CH_LBRK);
    for (int unsigned i = 0; i < SEQ_LEN + 1; i++) push_byte(8'(CH_ZERO + i));
    push_byte(CH_UA);
    // timeout boundary at the reset limit
    push_byte(CH_ESC); push_ticks(32'(ESC_TIMEOUT_RST), 1'b0);
    push_byte(CH_LBRK); push_byte(CH_UC);
    push_byte(CH_ESC); push_ticks(32'(ESC_TIMEOUT_RST) + 1, 1'b0); push_byte(CH_LBRK);

    // random phases, each under its own timeout
    limits = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd7, 16'd2,
               16'($urandom_range(0, 20)), 16'd50, 16'($urandom_range(0, 65535))};
    foreach (limits[p]) begin
      push_cfg(limits[p]);
      base = n_bytes;
      while (n_bytes - base < BYTES_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) push_escape(32'(limits[p]));
        else if (sel < 88) push_byte(8'($urandom_range(0, 255)));
        else if (sel < 97) push_ticks($urandom_range(1, 4), 1'b0);
        else push_pause();
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stim_q.size() != 0 || in_tvalid || cfg_valid || pause_wait || key_q.size() != 0);
    repeat (6) @(negedge clk);
    if (key_q.size() != 0) report_mismatch($sformatf("%0d results missing", key_q.size()));
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
